@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_PROP(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check a plain condition on every rising clk edge outside reset.
`define ASSERT_TRUE(label, cond) \
    `ASSERT_PROP(label, (cond))

`endif

@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;
    localparam int unsigned DATA_W        = 8;
    localparam int unsigned OCC_W         = 5;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } cell_op_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_t              op;
        logic [DATA_W-1:0]     elem;
        logic [DATA_W-1:0]     prio;
    } cell_cmd_t;

endpackage

@@ rtl/sorted_priority_queue.sv @@
`timescale 1ns / 1ps

// Sorted priority queue of DEPTH entries held in a chain of cells, head at
// cell 0. Each command (start high while busy is low) acts on the cells at the
// edge that takes it: an insert is placed behind all entries of higher or equal
// priority, a remove pops the head and moves every cell up by one. busy stays
// low, so a command may be issued on every cycle. The result appears
// on the cycle after the command with done high for exactly that cycle;
// the receiver cannot stall it and must take it then.

`include "assert_macros.svh"

module sorted_priority_queue #(
    parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       mode,
    input  logic [spq_pkg::DATA_W-1:0] element,
    input  logic [spq_pkg::DATA_W-1:0] priority_req,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [spq_pkg::DATA_W-1:0] out_element,
    output logic [spq_pkg::DATA_W-1:0] out_priority,
    output logic [spq_pkg::OCC_W-1:0]  occupancy
);
    import spq_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              done_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [DATA_W-1:0] out_elem_reg;
    logic [DATA_W-1:0] out_elem_next;
    logic [DATA_W-1:0] out_prio_reg;
    logic [DATA_W-1:0] out_prio_next;

    logic              accept;
    logic              full;
    logic              empty;
    cell_cmd_t         cmd;

    logic [DEPTH-1:0]  live;
    logic [DEPTH:0]    keep_chain;
    logic [DATA_W-1:0] cell_elem [DEPTH+1];
    logic [DATA_W-1:0] cell_prio [DEPTH+1];
    logic [CW+OCC_W-1:0] occ_wide;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);

    // Cell 0 has nothing ahead of it.
    assign keep_chain[0] = 1'b1;
    // Past the last cell nothing is live; the tail simply copies its own word.
    assign cell_elem[DEPTH] = cell_elem[DEPTH-1];
    assign cell_prio[DEPTH] = cell_prio[DEPTH-1];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] l_elem;
            logic [DATA_W-1:0] l_prio;

            assign live[gi] = (CW'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign l_elem = element;
                assign l_prio = priority_req;
            end
            else
            begin : g_body
                assign l_elem = cell_elem[gi-1];
                assign l_prio = cell_prio[gi-1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .live       (live[gi]),
                .prev_keep  (keep_chain[gi]),
                .left_elem  (l_elem),
                .left_prio  (l_prio),
                .right_elem (cell_elem[gi+1]),
                .right_prio (cell_prio[gi+1]),
                .keep       (keep_chain[gi+1]),
                .elem       (cell_elem[gi]),
                .prio       (cell_prio[gi])
            );
        end
    endgenerate

    always_comb
    begin
        cmd.op        = OP_HOLD;
        cmd.elem      = element;
        cmd.prio      = priority_req;
        count_next    = count_reg;
        status_next   = ST_DONE;
        out_elem_next = '0;
        out_prio_next = '0;
        if (accept)
        begin
            unique case (mode_t'(mode))
                MODE_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.op     = OP_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                end
                MODE_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        cmd.op        = OP_SHIFT;
                        count_next    = count_reg - CW'(1);
                        out_elem_next = cell_elem[0];
                        out_prio_next = cell_prio[0];
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        out_elem_reg <= out_elem_next;
        out_prio_reg <= out_prio_next;
    end

    // Occupancy is the live count taken to its 5-bit width.
    assign occ_wide     = {{OCC_W{1'b0}}, count_reg};
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_element  = out_elem_reg;
    assign out_priority = out_prio_reg;
    assign occupancy    = occ_wide[OCC_W-1:0];

    `ASSERT_TRUE(a_count_bound, count_reg <= CW'(DEPTH))
    `ASSERT_PROP(a_done_follows, accept |=> done_reg)
    `ASSERT_PROP(a_no_spurious_done, !accept |=> !done_reg)
    `ASSERT_PROP(a_overflow_full, (done_reg && status_reg == ST_OVERFLOW) |-> full)
    `ASSERT_PROP(a_underflow_empty, (done_reg && status_reg == ST_UNDERFLOW) |-> empty)
    `ASSERT_PROP(a_head_sorted, (count_reg >= CW'(2)) |-> (cell_prio[0] >= cell_prio[1]))

endmodule

@@ rtl/spq_cell.sv @@
`timescale 1ns / 1ps

module spq_cell (
    input  logic                       clk,
    input  spq_pkg::cell_cmd_t         cmd,
    input  logic                       live,
    input  logic                       prev_keep,
    input  logic [spq_pkg::DATA_W-1:0] left_elem,
    input  logic [spq_pkg::DATA_W-1:0] left_prio,
    input  logic [spq_pkg::DATA_W-1:0] right_elem,
    input  logic [spq_pkg::DATA_W-1:0] right_prio,
    output logic                       keep,
    output logic [spq_pkg::DATA_W-1:0] elem,
    output logic [spq_pkg::DATA_W-1:0] prio
);
    import spq_pkg::*;

    logic [DATA_W-1:0] elem_reg;
    logic [DATA_W-1:0] elem_next;
    logic [DATA_W-1:0] prio_reg;
    logic [DATA_W-1:0] prio_next;

    // Entry stays ahead of the new word when it is live and not lower.
    assign keep = live && (prio_reg >= cmd.prio);
    assign elem = elem_reg;
    assign prio = prio_reg;

    always_comb
    begin
        elem_next = elem_reg;
        prio_next = prio_reg;
        unique case (cmd.op)
            OP_INSERT:
            begin
                if (keep)
                begin
                    elem_next = elem_reg;
                    prio_next = prio_reg;
                end
                else if (prev_keep)
                begin
                    elem_next = cmd.elem;
                    prio_next = cmd.prio;
                end
                else
                begin
                    elem_next = left_elem;
                    prio_next = left_prio;
                end
            end
            OP_SHIFT:
            begin
                elem_next = right_elem;
                prio_next = right_prio;
            end
            default:
            begin
                elem_next = elem_reg;
                prio_next = prio_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
        prio_reg <= prio_next;
    end

endmodule

@@ tb/sv/spq_checker.sv @@
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              mode,
    input  logic [DATA_W-1:0] element,
    input  logic [DATA_W-1:0] priority_req,
    input  logic              done,
    input  logic [1:0]        status,
    input  logic [DATA_W-1:0] out_element,
    input  logic [DATA_W-1:0] out_priority,
    input  logic [OCC_W-1:0]  occupancy,
    output int                mismatches,
    output int                pending,
    output int                inserts_done,
    output int                removes_done,
    output int                overflows,
    output int                underflows,
    output int                peak_fill
);

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] elem;
        logic [DATA_W-1:0] prio;
        logic [OCC_W-1:0]  occ;
    } queue_result_t;

    logic [DATA_W-1:0] held_elem [DEPTH];
    logic [DATA_W-1:0] held_prio [DEPTH];
    int unsigned       held_count;
    queue_result_t     expected_results [$];

    // Apply one word to the shadow queue and return the result it should give.
    task automatic apply_queue_word(input mode_t m, input logic [DATA_W-1:0] e,
                                    input logic [DATA_W-1:0] p,
                                    output queue_result_t r);
        int unsigned pos;
        int unsigned i;
        r.status = ST_DONE;
        r.elem   = '0;
        r.prio   = '0;
        if (m == MODE_INSERT) begin
            if (held_count >= DEPTH) begin
                r.status = ST_OVERFLOW;
                overflows++;
            end
            else begin
                // place behind every entry of higher or equal rank
                pos = 0;
                while (pos < held_count && held_prio[pos] >= p)
                    pos++;
                for (i = held_count; i > pos; i--) begin
                    held_elem[i] = held_elem[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_elem[pos] = e;
                held_prio[pos] = p;
                held_count++;
                inserts_done++;
            end
        end
        else begin
            if (held_count == 0) begin
                r.status = ST_UNDERFLOW;
                underflows++;
            end
            else begin
                r.elem = held_elem[0];
                r.prio = held_prio[0];
                for (i = 1; i < held_count; i++) begin
                    held_elem[i-1] = held_elem[i];
                    held_prio[i-1] = held_prio[i];
                end
                held_count--;
                removes_done++;
            end
        end
        r.occ = OCC_W'(held_count);
        if (held_count > peak_fill)
            peak_fill = held_count;
    endtask

    always @(posedge clk or negedge rst_n) begin
        queue_result_t want;
        queue_result_t got;
        if (!rst_n) begin
            held_count = 0;
            expected_results.delete();
            mismatches   = 0;
            pending      = 0;
            inserts_done = 0;
            removes_done = 0;
            overflows    = 0;
            underflows   = 0;
            peak_fill    = 0;
        end
        else begin
            // a result belongs to a word taken at an earlier edge: check it first
            if (done) begin
                got.status = status_t'(status);
                got.elem   = out_element;
                got.prio   = out_priority;
                got.occ    = occupancy;
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("[%0t] result with nothing pending: status %0d elem %h "
                                 , $time, status, out_element,
                                 "prio %h occ %0d", out_priority, occupancy);
                    mismatches++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("[%0t] mismatch: expected status %0d elem %h prio %h occ %0d",
                                     $time, want.status, want.elem, want.prio, want.occ,
                                     " | got status %0d elem %h prio %h occ %0d",
                                     status, out_element, out_priority, occupancy);
                        mismatches++;
                    end
                end
            end
            if (start && !busy) begin
                apply_queue_word(mode_t'(mode), element, priority_req, want);
                expected_results.push_back(want);
            end
            pending = expected_results.size();
        end
    end

endmodule

@@ tb/sv/tb_sorted_priority_queue.sv @@
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 450;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              start        = 1'b0;
    logic              mode         = 1'b0;
    logic [DATA_W-1:0] element      = '0;
    logic [DATA_W-1:0] priority_req = '0;
    logic              busy;
    logic              done;
    logic [1:0]        status;
    logic [DATA_W-1:0] out_element;
    logic [DATA_W-1:0] out_priority;
    logic [OCC_W-1:0]  occupancy;

    int mismatches;
    int pending;
    int inserts_done;
    int removes_done;
    int overflows;
    int underflows;
    int peak_fill;
    int idle_pct = 0;
    int quiet_cycles;

    sorted_priority_queue uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .element      (element),
        .priority_req (priority_req),
        .done         (done),
        .status       (status),
        .out_element  (out_element),
        .out_priority (out_priority),
        .occupancy    (occupancy)
    );

    spq_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .element      (element),
        .priority_req (priority_req),
        .done         (done),
        .status       (status),
        .out_element  (out_element),
        .out_priority (out_priority),
        .occupancy    (occupancy),
        .mismatches   (mismatches),
        .pending      (pending),
        .inserts_done (inserts_done),
        .removes_done (removes_done),
        .overflows    (overflows),
        .underflows   (underflows),
        .peak_fill    (peak_fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hold a word on the inputs until the block takes it, after a random gap.
    task automatic send_queue_word(input mode_t m, input logic [DATA_W-1:0] e,
                                   input logic [DATA_W-1:0] p);
        logic taken;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        mode         <= m;
        element      <= e;
        priority_req <= p;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int               phase;
        int               n;
        int               insert_bias;
        logic [DATA_W-1:0] rank;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // remove from empty, then fill with extremes and ties
        send_queue_word(MODE_REMOVE, 8'h00, 8'h00);
        send_queue_word(MODE_INSERT, 8'h00, 8'h00);
        send_queue_word(MODE_INSERT, 8'hFF, 8'hFF);
        send_queue_word(MODE_INSERT, 8'hA5, 8'h80);
        send_queue_word(MODE_INSERT, 8'h5A, 8'h80);
        send_queue_word(MODE_INSERT, 8'h01, 8'h00);
        send_queue_word(MODE_INSERT, 8'hFE, 8'hFF);
        for (n = 0; n < 10; n++)
            send_queue_word(MODE_INSERT, 8'(8'h10 + n), 8'(n * 25));
        // full: must overflow
        send_queue_word(MODE_INSERT, 8'h77, 8'h77);
        // fields are don't-care on remove
        send_queue_word(MODE_REMOVE, 8'hFF, 8'hFF);
        send_queue_word(MODE_REMOVE, 8'h3C, 8'hC3);
        // reuse both freed slots, filling the queue again
        send_queue_word(MODE_INSERT, 8'h33, 8'hFF);
        send_queue_word(MODE_INSERT, 8'hCC, 8'h00);

        insert_bias = 50;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       idle_pct = 83;
                3:       idle_pct = 21;
                default: idle_pct = 0;
            endcase
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                // swing the mix so the queue runs both full and empty
                if (n % 30 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       insert_bias = 10;
                        1:       insert_bias = 50;
                        default: insert_bias = 90;
                    endcase
                end
                if ($urandom_range(0, 99) < insert_bias)
                begin
                    // narrow ranks at either end force many ties
                    if ($urandom_range(0, 2) == 0)
                        rank = {{6{1'($urandom_range(0, 1))}}, 2'($urandom)};
                    else
                        rank = 8'($urandom);
                    send_queue_word(MODE_INSERT, 8'($urandom), rank);
                end
                else
                    send_queue_word(MODE_REMOVE, 8'($urandom), 8'($urandom));
            end
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("covered %0d inserts, %0d removes, %0d overflows, %0d underflows",
                 inserts_done, removes_done, overflows, underflows);
        $display("peak fill %0d of %0d, %0d mismatches",
                 peak_fill, DEPTH_DEFAULT, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sorted_priority_queue.f @@
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sv/spq_checker.sv
tb/sv/tb_sorted_priority_queue.sv
